// ===== rtl/core/tlbd_pkg.sv =====
// shared constants, codes and control types of the two-locus birth-death step
`timescale 1ns / 1ps
package tlbd_pkg;

   localparam int COUNT_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int RATE_W    = 24;
   localparam int RECOMB_W  = 16;
   localparam int DRAW_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int FREQ_W    = FRAC_W + 1;
   localparam int TOTAL_W   = COUNT_W + 2;
   localparam int PB_W      = FRAC_W + 4;
   localparam int SB_W      = FREQ_W + RATE_W + 1 - FRAC_W + 1;
   localparam int WEIGHT_W  = SB_W + PB_W;
   localparam int WSUM_W    = WEIGHT_W + 3;
   localparam int NUM_EVENTS = 8;
   localparam int EV_IDX_W  = 3;
   localparam int EVENT_W   = 4;
   localparam int DIV_STEPS = FREQ_W;
   localparam int DIV_CNT_W = 5;

   localparam logic [EVENT_W-1:0] EVENT_NONE = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_BIG_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_SMALL_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEATH_BIG_A   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEATH_SMALL_A = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOMB        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COUNTS   = 3'd5;

   localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_MUL4,
      OP_MUL5,
      OP_SUM,
      OP_THR1,
      OP_THR2,
      OP_SCAN,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [EV_IDX_W-1:0]   idx;
   } dp_cmd_type;

   typedef struct packed {
      logic counts_empty;
      logic div_done;
   } dp_status_type;

endpackage

// ===== rtl/core/two_locus_birth_death_step.sv =====
// two-locus birth-death step: a restart or an empty population goes straight to the finish;
// an event runs the divide, multiply, sum, threshold, scan and finish steps in turn.
// one beat at a time; the 17-bit serial frequency divide and the serial weight
// sum and scan over eight events are serial; no new request is taken until the
// result beat is issued, and the finish waits while the previous result beat is not taken.
// synchronous active-high reset clears counts, rates to 1.0, r and initial counts to zero.
`timescale 1ns / 1ps
module two_locus_birth_death_step
   import tlbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_start_replicate,
   input  logic [DRAW_W-1:0]     req_uniform_draw,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_count_big_a_big_b,
   output logic [COUNT_W-1:0]    rsp_count_big_a_small_b,
   output logic [COUNT_W-1:0]    rsp_count_small_a_big_b,
   output logic [COUNT_W-1:0]    rsp_count_small_a_small_b,
   output logic [EVENT_W-1:0]    rsp_event_code,
   output logic                  rsp_population_extinct,
   output logic                  rsp_rescue_allele_lost,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   tlbd_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_replicate (req_start_replicate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .cmd                 (cmd),
      .status              (status)
   );

   // arithmetic and state
   tlbd_datapath u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_start_replicate       (req_start_replicate),
      .req_uniform_draw          (req_uniform_draw),
      .csr_write_enable          (csr_write_enable),
      .csr_index                 (csr_index),
      .csr_write_data            (csr_write_data),
      .rsp_count_big_a_big_b     (rsp_count_big_a_big_b),
      .rsp_count_big_a_small_b   (rsp_count_big_a_small_b),
      .rsp_count_small_a_big_b   (rsp_count_small_a_big_b),
      .rsp_count_small_a_small_b (rsp_count_small_a_small_b),
      .rsp_event_code            (rsp_event_code),
      .rsp_population_extinct    (rsp_population_extinct),
      .rsp_rescue_allele_lost    (rsp_rescue_allele_lost)
   );

   // one beat in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a step is in progress");

   // an extinct step reports no event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_population_extinct |-> rsp_event_code == EVENT_NONE)
      else $error("event reported on an empty population");

   // event code stays within the eight events or none
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_code <= EVENT_NONE)
      else $error("event code out of range");

endmodule

// ===== rtl/core/tlbd_div_lane.sv =====
// bit-serial restoring divider: (n << 16) / total, one quotient bit a cycle
`timescale 1ns / 1ps
module tlbd_div_lane
   import tlbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COUNT_W-1:0] dividend,
   input  logic [TOTAL_W-1:0] divisor,
   output logic [FREQ_W-1:0]  quotient,
   output logic               busy
);

   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0]   div_ff;
   logic [FREQ_W-1:0]    q_ff, q_in;
   logic [DIV_CNT_W-1:0] step_ff;
   logic                 busy_ff;
   logic [TOTAL_W:0]     trial;
   logic                 fits;

   // first step compares n itself, later steps shift in a zero bit
   always_comb begin
      if (step_ff == '0) begin
         trial = {1'b0, rem_ff};
      end else begin
         trial = {rem_ff, 1'b0};
      end
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? TOTAL_W'(trial - {1'b0, div_ff}) : TOTAL_W'(trial);
      q_in   = {q_ff[FREQ_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= TOTAL_W'(dividend);
         div_ff <= divisor;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign quotient = q_ff;
   assign busy     = busy_ff;

endmodule

// ===== rtl/core/tlbd_datapath.sv =====
// datapath: config registers, counts, frequencies, weights, draw threshold and event scan
`timescale 1ns / 1ps
module tlbd_datapath
   import tlbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  req_start_replicate,
   input  logic [DRAW_W-1:0]     req_uniform_draw,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic [COUNT_W-1:0]    rsp_count_big_a_big_b,
   output logic [COUNT_W-1:0]    rsp_count_big_a_small_b,
   output logic [COUNT_W-1:0]    rsp_count_small_a_big_b,
   output logic [COUNT_W-1:0]    rsp_count_small_a_small_b,
   output logic [EVENT_W-1:0]    rsp_event_code,
   output logic                  rsp_population_extinct,
   output logic                  rsp_rescue_allele_lost
);

   logic [RATE_W-1:0]     rate_ff [4];
   logic [RECOMB_W-1:0]   recomb_ff;
   logic [CSR_DATA_W-1:0] init_ff;
   logic [COUNT_W-1:0]    counts_ff [4];
   logic [COUNT_W-1:0]    counts_in [4];

   logic                  start_ff;
   logic                  empty_ff;
   logic [DRAW_W-1:0]     draw_ff;

   logic [TOTAL_W-1:0]    total_cnt;
   logic [FREQ_W-1:0]     freq [4];
   logic [3:0]            lane_busy;

   logic [2*FREQ_W-1:0]   p_ad_ff, p_bc_ff;
   logic [FREQ_W+RATE_W-1:0] s_big_ff, s_small_ff;
   logic                  d_neg_ff;
   logic [FREQ_W+1:0]     d_mag_ff;
   logic [SB_W-1:0]       sb_ff;
   logic [RECOMB_W+FREQ_W+1:0] rd_prod_ff;
   logic [PB_W-1:0]       pb_ff [4];
   logic [WEIGHT_W-1:0]   w_ff [NUM_EVENTS];
   logic [WSUM_W-1:0]     acc_ff, acc_in;
   logic [63:0]           lo_ff;
   logic [WSUM_W-1:0]     hi_ff;
   logic [WSUM_W-1:0]     thr_ff;
   logic                  found_ff;
   logic [EVENT_W-1:0]    ev_ff;

   logic [2*FREQ_W:0]     diff;
   logic [2*FREQ_W-1:0]   diff_mag;
   logic [FREQ_W+RATE_W:0] s_sum;
   logic [FREQ_W+1:0]     rd_mag;
   logic [FREQ_W:0]       freq_big, freq_small;
   logic [WSUM_W:0]       thr_sum;
   logic                  ev_birth;
   logic [1:0]            ev_slot;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rate_ff[i] <= RATE_RESET;
         end
         recomb_ff <= '0;
         init_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIRTH_BIG_A:   rate_ff[0] <= csr_write_data[RATE_W-1:0];
            CSR_BIRTH_SMALL_A: rate_ff[1] <= csr_write_data[RATE_W-1:0];
            CSR_DEATH_BIG_A:   rate_ff[2] <= csr_write_data[RATE_W-1:0];
            CSR_DEATH_SMALL_A: rate_ff[3] <= csr_write_data[RATE_W-1:0];
            CSR_RECOMB:        recomb_ff  <= csr_write_data[RECOMB_W-1:0];
            CSR_INIT_COUNTS:   init_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // population total and frequency lanes
   assign total_cnt = TOTAL_W'(counts_ff[0]) + TOTAL_W'(counts_ff[1])
                    + TOTAL_W'(counts_ff[2]) + TOTAL_W'(counts_ff[3]);

   for (genvar g = 0; g < 4; g++) begin : g_lane
      tlbd_div_lane u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.op == OP_LOAD),
         .dividend (counts_ff[g]),
         .divisor  (total_cnt),
         .quotient (freq[g]),
         .busy     (lane_busy[g])
      );
   end

   assign status.counts_empty = (total_cnt == '0);
   assign status.div_done     = (lane_busy == 4'b0000);

   // combinational helpers for the stages
   always_comb begin
      freq_big   = (FREQ_W+1)'(freq[0]) + (FREQ_W+1)'(freq[1]);
      freq_small = (FREQ_W+1)'(freq[2]) + (FREQ_W+1)'(freq[3]);
      diff       = {1'b0, p_ad_ff} - {1'b0, p_bc_ff};
      diff_mag   = diff[2*FREQ_W] ? (2*FREQ_W)'(~diff + 1'b1) : diff[2*FREQ_W-1:0];
      s_sum      = (FREQ_W+RATE_W+1)'(s_big_ff) + (FREQ_W+RATE_W+1)'(s_small_ff);
      rd_mag     = rd_prod_ff[RECOMB_W+FREQ_W+1:FRAC_W];
      thr_sum    = (WSUM_W+1)'(hi_ff) + (WSUM_W+1)'(lo_ff[63:32]);
      acc_in     = acc_ff + WSUM_W'(w_ff[cmd.idx]);
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            start_ff <= req_start_replicate;
            draw_ff  <= req_uniform_draw;
            empty_ff <= (total_cnt == '0);
            acc_ff   <= '0;
            found_ff <= 1'b0;
            ev_ff    <= EVENT_NONE;
         end
         OP_MUL1: begin
            p_ad_ff    <= freq[0] * freq[3];
            p_bc_ff    <= freq[1] * freq[2];
            s_big_ff   <= (FREQ_W+RATE_W)'(freq_big * rate_ff[0]);
            s_small_ff <= (FREQ_W+RATE_W)'(freq_small * rate_ff[1]);
         end
         OP_MUL2: begin
            d_neg_ff <= diff[2*FREQ_W];
            d_mag_ff <= (FREQ_W+2)'(diff_mag >> FRAC_W);
            sb_ff    <= SB_W'(s_sum >> FRAC_W);
         end
         OP_MUL3: begin
            rd_prod_ff <= (RECOMB_W+FREQ_W+2)'(recomb_ff * d_mag_ff);
         end
         OP_MUL4: begin
            // coupling genotypes lose r*D, repulsion genotypes gain it
            for (int i = 0; i < 4; i++) begin
               if ((i == 0 || i == 3) != d_neg_ff) begin
                  pb_ff[i] <= (PB_W'(freq[i]) >= PB_W'(rd_mag))
                            ? PB_W'(PB_W'(freq[i]) - PB_W'(rd_mag)) : '0;
               end else begin
                  pb_ff[i] <= PB_W'(freq[i]) + PB_W'(rd_mag);
               end
            end
         end
         OP_MUL5: begin
            for (int i = 0; i < 4; i++) begin
               w_ff[i]     <= WEIGHT_W'(sb_ff * pb_ff[i]);
               w_ff[4 + i] <= WEIGHT_W'(freq[i] * rate_ff[(i < 2) ? 2 : 3]);
            end
         end
         OP_SUM: begin
            acc_ff <= acc_in;
         end
         OP_THR1: begin
            lo_ff <= acc_ff[31:0] * draw_ff;
            hi_ff <= WSUM_W'(acc_ff[WSUM_W-1:32] * draw_ff);
         end
         OP_THR2: begin
            thr_ff <= thr_sum[WSUM_W-1:0];
            acc_ff <= '0;
         end
         OP_SCAN: begin
            acc_ff <= acc_in;
            if (!found_ff && acc_in > thr_ff) begin
               found_ff <= 1'b1;
               ev_ff    <= EVENT_W'(cmd.idx);
            end
         end
         default: ;
      endcase
   end

   // count update for the chosen event
   assign ev_birth = (ev_ff < EVENT_W'(4));
   assign ev_slot  = ev_ff[1:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         counts_in[i] = counts_ff[i];
         if (start_ff) begin
            counts_in[i] = init_ff[COUNT_W*i +: COUNT_W];
         end else if (!empty_ff && found_ff && ev_slot == 2'(i)) begin
            if (ev_birth) begin
               if (counts_ff[i] != '1) counts_in[i] = counts_ff[i] + 1'b1;
            end else begin
               if (counts_ff[i] != '0) counts_in[i] = counts_ff[i] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (cmd.op == OP_FINISH) begin
         counts_ff <= counts_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_FINISH) begin
         rsp_count_big_a_big_b     <= counts_in[0];
         rsp_count_big_a_small_b   <= counts_in[1];
         rsp_count_small_a_big_b   <= counts_in[2];
         rsp_count_small_a_small_b <= counts_in[3];
         rsp_event_code            <= (start_ff || empty_ff) ? EVENT_NONE : ev_ff;
         rsp_population_extinct    <= !start_ff && empty_ff;
         rsp_rescue_allele_lost    <= (counts_in[0] == '0) && (counts_in[1] == '0);
      end
   end

endmodule

// ===== rtl/core/tlbd_ctrl.sv =====
// controller: sequences one step through divide, multiply, sum, threshold and scan, or straight to done
`timescale 1ns / 1ps
module tlbd_ctrl
   import tlbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_start_replicate,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_MUL4,
      S_MUL5,
      S_SUM,
      S_THR1,
      S_THR2,
      S_SCAN,
      S_DONE
   } state_type;

   state_type           state_ff;
   logic [EV_IDX_W-1:0] idx_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd.idx = idx_ff;
      case (state_ff)
         S_IDLE:  cmd.op = req_valid ? OP_LOAD : OP_IDLE;
         S_MUL1:  cmd.op = OP_MUL1;
         S_MUL2:  cmd.op = OP_MUL2;
         S_MUL3:  cmd.op = OP_MUL3;
         S_MUL4:  cmd.op = OP_MUL4;
         S_MUL5:  cmd.op = OP_MUL5;
         S_SUM:   cmd.op = OP_SUM;
         S_THR1:  cmd.op = OP_THR1;
         S_THR2:  cmd.op = OP_THR2;
         S_SCAN:  cmd.op = OP_SCAN;
         S_DONE:  cmd.op = out_free ? OP_FINISH : OP_IDLE;
         default: cmd.op = OP_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the done state a taken beat is replaced by the new one
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_start_replicate || status.counts_empty) ? S_DONE : S_DIV;
               end
            end
            S_DIV: begin
               if (status.div_done) state_ff <= S_MUL1;
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_MUL3;
            S_MUL3: state_ff <= S_MUL4;
            S_MUL4: state_ff <= S_MUL5;
            S_MUL5: begin
               state_ff <= S_SUM;
               idx_ff   <= '0;
            end
            S_SUM: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == EV_IDX_W'(NUM_EVENTS - 1)) state_ff <= S_THR1;
            end
            S_THR1: state_ff <= S_THR2;
            S_THR2: begin
               state_ff <= S_SCAN;
               idx_ff   <= '0;
            end
            S_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == EV_IDX_W'(NUM_EVENTS - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
